// ===== hdl/ttp_pkg.sv =====
// shared types and constants for the tanh threshold projection core
// no dependencies
package ttp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int D_W   = 17;          // density and projection, Q1.16
    localparam int B_W   = 16;          // steepness, Q8.8
    localparam int G_W   = 32;          // gradient, Q16.16
    localparam int ARG_W = D_W + B_W;   // tanh argument, Q9.24
    localparam int X_W   = 31;          // exp series values, Q1.30

    localparam logic [D_W-1:0]   ONE_Q16       = 17'd65536;
    localparam logic [G_W-1:0]   GRAD_ONE      = 32'd65536;
    localparam logic [D_W-1:0]   THRESHOLD_RST = 17'd32768;
    localparam logic [B_W-1:0]   STEEPNESS_RST = 16'd0;
    localparam logic [X_W-1:0]   ONE_Q30       = 31'h4000_0000;
    localparam logic [ARG_W-1:0] ARG_LIMIT     = 33'd134217728;  // 8.0 in Q9.24

    localparam int TERM_N = 12;  // taylor terms of exp(-w)
    localparam int SQ_N   = 4;   // squarings, exp(-16w)

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_STEEPNESS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [X_W-1:0] term;
        logic [X_W-1:0] w;
        logic [31:0]    pos;
        logic [31:0]    neg;
        logic           sat;
    } term_state_t;

    // prep, taylor cells, difference, squarings, divider load, divider steps
    function automatic int tanh_latency(input int frac);
        return 3 * TERM_N + SQ_N + 3 + frac + 1;
    endfunction

endpackage

// ===== hdl/tanh_threshold_projection_core.sv =====
// throughput: one item per cycle; the pipeline freezes only when its last stage and the
// output register are both full and m_ready is low
// reset: synchronous active-low aresetn clears the valid bits, threshold to 0.5, steepness to 0
// depends on ttp_pkg, ttp_tanh, ttp_div
module tanh_threshold_projection_core
    import ttp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [0:0]     cfg_index,
    input  logic [D_W-1:0] cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [D_W-1:0] s_density,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [D_W-1:0] m_projected,
    output logic [G_W-1:0] m_gradient
);

    localparam int T_W      = FRAC_BITS + 1;
    localparam int DEN_W    = FRAC_BITS + 2;
    localparam int S_W      = FRAC_BITS + 1;
    localparam int BS_W     = B_W + S_W;
    localparam int G_NUM_W  = BS_W + 9;
    localparam int PIPE_LAT = 1 + tanh_latency(FRAC_BITS) + 3 + G_NUM_W + 1;
    localparam logic [S_W-1:0] S_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration
    logic [D_W-1:0] threshold_reg;
    logic [B_W-1:0] steepness_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            steepness_reg <= STEEPNESS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                REG_STEEPNESS: steepness_reg <= cfg_wdata[B_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic                en;
    logic                last_v;
    logic [PIPE_LAT-1:0] v_reg;
    logic                m_valid_reg;

    assign last_v  = v_reg[PIPE_LAT-1];
    assign en      = !last_v || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    // tanh arguments
    logic [D_W-1:0]   d_c;
    logic [D_W-1:0]   e_c;
    logic             t2neg_next;
    logic [D_W-1:0]   diff;
    logic [ARG_W-1:0] a1_reg;
    logic [ARG_W-1:0] a2_reg;
    logic [ARG_W-1:0] a3_reg;
    logic [D_W-1:0]   d0_reg;
    logic [B_W-1:0]   b0_reg;
    logic             t2neg0_reg;

    assign d_c        = (s_density > ONE_Q16) ? ONE_Q16 : s_density;
    assign e_c        = (threshold_reg > ONE_Q16) ? ONE_Q16 : threshold_reg;
    assign t2neg_next = d_c < e_c;
    assign diff       = t2neg_next ? e_c - d_c : d_c - e_c;

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg     <= ARG_W'(steepness_reg) * ARG_W'(e_c);
            a2_reg     <= ARG_W'(steepness_reg) * ARG_W'(diff);
            a3_reg     <= ARG_W'(steepness_reg) * ARG_W'(ONE_Q16 - e_c);
            d0_reg     <= d_c;
            b0_reg     <= steepness_reg;
            t2neg0_reg <= t2neg_next;
        end
    end

    // three tanh lanes, sideband split across them
    logic [T_W-1:0] t1;
    logic [T_W-1:0] t2m;
    logic [T_W-1:0] t3;
    logic [B_W-1:0] b_t;
    logic           t2neg_t;
    logic [D_W-1:0] d_t;

    ttp_tanh #(.FRAC_BITS(FRAC_BITS), .SB_W(B_W)) u_tanh_e (
        .aclk (aclk), .en (en), .mag (a1_reg), .sb_in (b0_reg),
        .t_out (t1), .sb_out (b_t)
    );

    ttp_tanh #(.FRAC_BITS(FRAC_BITS), .SB_W(1)) u_tanh_d (
        .aclk (aclk), .en (en), .mag (a2_reg), .sb_in (t2neg0_reg),
        .t_out (t2m), .sb_out (t2neg_t)
    );

    ttp_tanh #(.FRAC_BITS(FRAC_BITS), .SB_W(D_W)) u_tanh_one (
        .aclk (aclk), .en (en), .mag (a3_reg), .sb_in (d0_reg),
        .t_out (t3), .sb_out (d_t)
    );

    // numerator, denominator, square of the middle tanh
    logic [DEN_W-1:0]  num1_next;
    logic [DEN_W-1:0]  num1_reg;
    logic [DEN_W-1:0]  den1_reg;
    logic [2*T_W-1:0]  sq1_reg;
    logic [B_W-1:0]    b1_reg;
    logic [D_W-1:0]    d1_reg;

    always_comb begin
        if (t2neg_t) begin
            num1_next = (t2m > t1) ? '0 : DEN_W'(t1 - t2m);
        end else begin
            num1_next = DEN_W'(t1) + DEN_W'(t2m);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg <= num1_next;
            den1_reg <= DEN_W'(t1) + DEN_W'(t3);
            sq1_reg  <= (2*T_W)'(t2m) * (2*T_W)'(t2m);
            b1_reg   <= b_t;
            d1_reg   <= d_t;
        end
    end

    // s = 1 - t^2, bypass when the steepness or the denominator is zero
    logic [2*T_W-1:0] sq_r;
    logic [S_W-1:0]   s_next;
    logic [S_W-1:0]   s2_reg;
    logic             byp2_reg;
    logic [DEN_W-1:0] num2_reg;
    logic [DEN_W-1:0] den2_reg;
    logic [B_W-1:0]   b2_reg;
    logic [D_W-1:0]   d2_reg;

    assign sq_r   = (sq1_reg + (2*T_W)'(S_ONE >> 1)) >> FRAC_BITS;
    assign s_next = (sq_r >= (2*T_W)'(S_ONE)) ? '0 : S_ONE - S_W'(sq_r);

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg   <= s_next;
            byp2_reg <= (b1_reg == '0) || (den1_reg == '0);
            num2_reg <= num1_reg;
            den2_reg <= den1_reg;
            b2_reg   <= b1_reg;
            d2_reg   <= d1_reg;
        end
    end

    logic [BS_W-1:0]  bs3_reg;
    logic             byp3_reg;
    logic [DEN_W-1:0] num3_reg;
    logic [DEN_W-1:0] den3_reg;
    logic [D_W-1:0]   d3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            bs3_reg  <= BS_W'(b2_reg) * BS_W'(s2_reg);
            byp3_reg <= byp2_reg;
            num3_reg <= num2_reg;
            den3_reg <= den2_reg;
            d3_reg   <= d2_reg;
        end
    end

    // both divisions share one depth so their results line up
    logic [G_NUM_W-1:0] pdiv_num;
    logic [G_NUM_W-1:0] gdiv_num;
    logic [G_NUM_W-1:0] qp;
    logic [G_NUM_W-1:0] qg;
    logic [D_W-1:0]     d_q;
    logic               byp_q;

    assign pdiv_num = (G_NUM_W'(num3_reg) << 16) + G_NUM_W'(den3_reg >> 1);
    assign gdiv_num = (G_NUM_W'(bs3_reg) << 8) + G_NUM_W'(den3_reg >> 1);

    ttp_div #(
        .NUM_W (G_NUM_W), .DEN_W (DEN_W), .Q_W (G_NUM_W), .SB_W (D_W)
    ) u_div_proj (
        .aclk (aclk), .en (en), .num (pdiv_num), .den (den3_reg), .sb_in (d3_reg),
        .quo (qp), .sb_out (d_q)
    );

    ttp_div #(
        .NUM_W (G_NUM_W), .DEN_W (DEN_W), .Q_W (G_NUM_W), .SB_W (1)
    ) u_div_grad (
        .aclk (aclk), .en (en), .num (gdiv_num), .den (den3_reg), .sb_in (byp3_reg),
        .quo (qg), .sb_out (byp_q)
    );

    // saturation and pass-through
    logic [D_W-1:0] proj_f_reg;
    logic [G_W-1:0] grad_f_reg;
    logic [D_W-1:0] proj_next;
    logic [G_W-1:0] grad_next;

    always_comb begin
        if (byp_q) begin
            proj_next = d_q;
            grad_next = GRAD_ONE;
        end else begin
            proj_next = (qp > G_NUM_W'(ONE_Q16)) ? ONE_Q16 : qp[D_W-1:0];
            grad_next = ((qg >> G_W) != '0) ? '1 : qg[G_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            proj_f_reg <= proj_next;
            grad_f_reg <= grad_next;
        end
    end

    // output register
    logic [D_W-1:0] m_projected_reg;
    logic [G_W-1:0] m_gradient_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (en && last_v) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && last_v) begin
            m_projected_reg <= proj_f_reg;
            m_gradient_reg  <= grad_f_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_projected = m_projected_reg;
    assign m_gradient  = m_gradient_reg;

endmodule

// ===== hdl/ttp_div.sv =====
// pipelined restoring divider, one quotient bit per cell, sideband carried along
// no dependencies; caller guarantees the quotient fits in Q_W bits
module ttp_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 17,
    parameter int SB_W  = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic [Q_W-1:0]   quo,
    output logic [SB_W-1:0]  sb_out
);

    logic [DEN_W-1:0] r_reg   [Q_W];
    logic [Q_W-1:0]   acc_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [SB_W-1:0]  sb_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   acc_in;
        logic [SB_W-1:0]  sb_k;
        logic [DEN_W:0]   trial;
        logic             fits;
        logic [DEN_W-1:0] r_next;
        logic [Q_W-1:0]   acc_next;

        if (k == 0) begin : g_first
            // upper dividend bits are already below the divisor
            assign r_in   = DEN_W'(num >> Q_W);
            assign acc_in = num[Q_W-1:0];
            assign den_in = den;
            assign sb_k   = sb_in;
        end else begin : g_rest
            assign r_in   = r_reg[k-1];
            assign acc_in = acc_reg[k-1];
            assign den_in = den_reg[k-1];
            assign sb_k   = sb_reg[k-1];
        end

        assign trial    = {r_in, acc_in[Q_W-1]};
        assign fits     = trial >= {1'b0, den_in};
        assign r_next   = fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        assign acc_next = {acc_in[Q_W-2:0], fits};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= r_next;
                acc_reg[k] <= acc_next;
                den_reg[k] <= den_in;
                sb_reg[k]  <= sb_k;
            end
        end
    end

    assign quo    = acc_reg[Q_W-1];
    assign sb_out = sb_reg[Q_W-1];

endmodule

// ===== hdl/ttp_term_cell.sv =====
// one taylor term of exp(-w): multiply, reciprocal divide, correct and accumulate
// depends on ttp_pkg
module ttp_term_cell
    import ttp_pkg::*;
#(
    parameter int N    = 1,
    parameter int SB_W = 1
) (
    input  logic            aclk,
    input  logic            en,
    input  term_state_t     st_in,
    input  logic [SB_W-1:0] sb_in,
    output term_state_t     st_out,
    output logic [SB_W-1:0] sb_out
);

    localparam logic [31:0]    RECIP = 32'(64'd4294967295 / N);
    localparam logic [X_W-1:0] N_K   = X_W'(N);

    logic [2*X_W-1:0] prod_a;
    term_state_t      st_a_reg;
    logic [X_W-1:0]   x_a_reg;
    logic [SB_W-1:0]  sb_a_reg;

    logic [62:0]      prod_b;
    term_state_t      st_b_reg;
    logic [X_W-1:0]   x_b_reg;
    logic [X_W-1:0]   q_b_reg;
    logic [SB_W-1:0]  sb_b_reg;

    logic [X_W-1:0]   qn;
    logic [X_W-1:0]   rem;
    logic [X_W-1:0]   term_next;
    term_state_t      st_next;
    term_state_t      st_c_reg;
    logic [SB_W-1:0]  sb_c_reg;

    assign prod_a = (2*X_W)'(st_in.term) * (2*X_W)'(st_in.w);

    always_ff @(posedge aclk) begin
        if (en) begin
            st_a_reg <= st_in;
            x_a_reg  <= prod_a[2*X_W-2:X_W-1];
            sb_a_reg <= sb_in;
        end
    end

    // quotient estimate, low by at most one
    assign prod_b = 63'(x_a_reg) * 63'(RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            st_b_reg <= st_a_reg;
            x_b_reg  <= x_a_reg;
            q_b_reg  <= prod_b[62:32];
            sb_b_reg <= sb_a_reg;
        end
    end

    always_comb begin
        qn        = q_b_reg * N_K;
        rem       = x_b_reg - qn;
        term_next = q_b_reg + X_W'(rem >= N_K);
        st_next   = st_b_reg;
        st_next.term = term_next;
        if (N % 2 == 1) begin
            st_next.neg = st_b_reg.neg + 32'(term_next);
        end else begin
            st_next.pos = st_b_reg.pos + 32'(term_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_c_reg <= st_next;
            sb_c_reg <= sb_b_reg;
        end
    end

    assign st_out = st_c_reg;
    assign sb_out = sb_c_reg;

endmodule

// ===== hdl/ttp_tanh.sv =====
// tanh of a non-negative Q9.24 magnitude, result in Q.FRAC_BITS
// depends on ttp_pkg, ttp_term_cell, ttp_div
module ttp_tanh
    import ttp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SB_W      = 1
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [ARG_W-1:0]   mag,
    input  logic [SB_W-1:0]    sb_in,
    output logic [FRAC_BITS:0] t_out,
    output logic [SB_W-1:0]    sb_out
);

    localparam int SH     = 24 - FRAC_BITS;
    localparam int DIVN_W = FRAC_BITS + 32;
    localparam logic [ARG_W-1:0] RND = (ARG_W'(1) << SH) >> 1;

    // input rounding, magnitude m to w = m/8 in Q1.30, so that exp(-16w) = exp(-2m)
    logic [ARG_W-1:0] mag_rnd;
    term_state_t      st0_next;
    term_state_t      st0_reg;
    logic [SB_W-1:0]  sb0_reg;

    assign mag_rnd = mag + RND;

    always_comb begin
        st0_next.term = ONE_Q30;
        st0_next.w    = X_W'((mag_rnd >> SH) << (27 - FRAC_BITS));
        st0_next.pos  = 32'(ONE_Q30);
        st0_next.neg  = '0;
        st0_next.sat  = mag >= ARG_LIMIT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_reg <= st0_next;
            sb0_reg <= sb_in;
        end
    end

    term_state_t     st_w [TERM_N+1];
    logic [SB_W-1:0] sb_w [TERM_N+1];

    assign st_w[0] = st0_reg;
    assign sb_w[0] = sb0_reg;

    for (genvar n = 0; n < TERM_N; n++) begin : g_term
        ttp_term_cell #(
            .N    (n + 1),
            .SB_W (SB_W)
        ) u_term (
            .aclk   (aclk),
            .en     (en),
            .st_in  (st_w[n]),
            .sb_in  (sb_w[n]),
            .st_out (st_w[n+1]),
            .sb_out (sb_w[n+1])
        );
    end

    // entry 0 holds exp(-w), entries 1.. the squarings
    logic [31:0]     sq_reg     [SQ_N+1];
    logic            sat_sq_reg [SQ_N+1];
    logic [SB_W-1:0] sb_sq_reg  [SQ_N+1];
    logic [31:0]     v_next;

    assign v_next = (st_w[TERM_N].pos > st_w[TERM_N].neg) ?
                    st_w[TERM_N].pos - st_w[TERM_N].neg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg[0]     <= v_next;
            sat_sq_reg[0] <= st_w[TERM_N].sat;
            sb_sq_reg[0]  <= sb_w[TERM_N];
        end
    end

    for (genvar k = 1; k <= SQ_N; k++) begin : g_sq
        logic [63:0] prod;
        assign prod = 64'(sq_reg[k-1]) * 64'(sq_reg[k-1]) + 64'(32'h2000_0000);
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[k]     <= prod[61:30];
                sat_sq_reg[k] <= sat_sq_reg[k-1];
                sb_sq_reg[k]  <= sb_sq_reg[k-1];
            end
        end
    end

    // (1 - q) / (1 + q), rounded
    logic [X_W-1:0]    q;
    logic [31:0]       dden_next;
    logic [DIVN_W-1:0] dnum_next;
    logic [DIVN_W-1:0] dnum_reg;
    logic [31:0]       dden_reg;
    logic              sat_d_reg;
    logic [SB_W-1:0]   sb_d_reg;

    assign q         = (sq_reg[SQ_N] > 32'(ONE_Q30)) ? ONE_Q30 : sq_reg[SQ_N][X_W-1:0];
    assign dden_next = 32'(ONE_Q30) + 32'(q);
    assign dnum_next = (DIVN_W'(ONE_Q30 - q) << FRAC_BITS) + DIVN_W'(dden_next >> 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            dnum_reg  <= dnum_next;
            dden_reg  <= dden_next;
            sat_d_reg <= sat_sq_reg[SQ_N];
            sb_d_reg  <= sb_sq_reg[SQ_N];
        end
    end

    logic [FRAC_BITS:0] quo;
    logic               sat_o;

    ttp_div #(
        .NUM_W (DIVN_W),
        .DEN_W (32),
        .Q_W   (FRAC_BITS + 1),
        .SB_W  (SB_W + 1)
    ) u_div (
        .aclk   (aclk),
        .en     (en),
        .num    (dnum_reg),
        .den    (dden_reg),
        .sb_in  ({sat_d_reg, sb_d_reg}),
        .quo    (quo),
        .sb_out ({sat_o, sb_out})
    );

    assign t_out = sat_o ? {1'b1, {FRAC_BITS{1'b0}}} : quo;

endmodule

// ===== hdl/ttp_checker.sv =====
// port-level checks for the tanh threshold projection core, bound to the top level
// depends on ttp_pkg and tanh_threshold_projection_core
module ttp_checker
    import ttp_pkg::*;
(
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input logic [D_W-1:0] m_projected,
    input logic [G_W-1:0] m_gradient
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a free output register never holds back the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // projection saturates at one
    a_proj_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_projected <= ONE_Q16)
        else $error("projected density above one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_projected) && $stable(m_gradient))
        else $error("stalled item changed");

endmodule

bind tanh_threshold_projection_core ttp_checker u_ttp_checker (.*);

// ===== dv/tanh_threshold_projection_checker.sv =====
// scoreboard for the tanh threshold projection core: predicts each result from
// accepted items and its own copy of the registers, compares the result channel
// depends on ttp_pkg
module tanh_threshold_projection_checker
    import ttp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [0:0]     cfg_index,
    input  logic [D_W-1:0] cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  logic [D_W-1:0] s_density,
    input  logic           m_valid,
    input  logic           m_ready,
    input  logic [D_W-1:0] m_projected,
    input  logic [G_W-1:0] m_gradient,
    output int             mismatch_cnt,
    output int             pending_cnt,
    output int             result_cnt
);

    localparam int FB = FRAC_BITS_DEF;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef struct {
        logic [D_W-1:0] projected;
        logic [G_W-1:0] gradient;
    } projection_t;

    projection_t    expected_q[$];
    logic [D_W-1:0] thr_copy;
    logic [B_W-1:0] steep_copy;

    // exp(-16w) for w in Q2.30
    function automatic logic [63:0] exp_neg16(input logic [63:0] w);
        logic [63:0] pos, neg, term, v;
        pos = Q30;
        neg = 0;
        term = Q30;
        for (int n = 1; n <= TERM_N; n++) begin
            term = ((term * w) >> 30) / n;
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        v = (pos > neg) ? pos - neg : 0;
        for (int k = 0; k < SQ_N; k++) v = (v * v + (Q30 >> 1)) >> 30;
        return v;
    endfunction

    // tanh of a Q9.24 magnitude, result in Q.FB
    function automatic logic [63:0] tanh_q(input logic [63:0] a);
        logic [63:0] m, q, num, den;
        if (a >= 64'(ARG_LIMIT)) return 64'd1 << FB;
        m = (a + (64'd1 << (24 - FB - 1))) >> (24 - FB);
        q = exp_neg16((2 * m) << (26 - FB));
        if (q > Q30) q = Q30;
        num = (Q30 - q) << FB;
        den = Q30 + q;
        return (num + den / 2) / den;
    endfunction

    function automatic projection_t project(input logic [D_W-1:0] density);
        logic [63:0] d, e, b, t1, t2, t3, num, den, s, p, g;
        logic below;
        projection_t r;
        d = (density > ONE_Q16) ? 64'(ONE_Q16) : 64'(density);
        e = (thr_copy > ONE_Q16) ? 64'(ONE_Q16) : 64'(thr_copy);
        b = 64'(steep_copy);
        den = 0;
        t2 = 0;
        num = 0;
        if (b != 0) begin
            t1 = tanh_q(b * e);
            below = d < e;
            t2 = tanh_q(b * (below ? e - d : d - e));
            t3 = tanh_q(b * (64'(ONE_Q16) - e));
            den = t1 + t3;
            if (below) num = (t2 > t1) ? 0 : t1 - t2;
            else num = t1 + t2;
        end
        if (den == 0) begin
            r.projected = D_W'(d);
            r.gradient = GRAD_ONE;
            return r;
        end
        p = ((num << 16) + den / 2) / den;
        if (p > 64'(ONE_Q16)) p = 64'(ONE_Q16);
        s = (t2 * t2 + ((64'd1 << FB) >> 1)) >> FB;
        s = (s >= (64'd1 << FB)) ? 0 : (64'd1 << FB) - s;
        g = (b * s * 256 + den / 2) / den;
        if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
        r.projected = D_W'(p);
        r.gradient = G_W'(g);
        return r;
    endfunction

    assign pending_cnt = expected_q.size();

    initial begin
        mismatch_cnt = 0;
        result_cnt = 0;
    end

    always @(posedge aclk) begin
        projection_t want;
        if (!aresetn) begin
            thr_copy <= THRESHOLD_RST;
            steep_copy <= STEEPNESS_RST;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_THRESHOLD) thr_copy <= cfg_wdata;
                else if (cfg_index == REG_STEEPNESS) steep_copy <= cfg_wdata[B_W-1:0];
            end
            if (s_valid && s_ready) expected_q.push_back(project(s_density));
            if (m_valid && m_ready) begin
                result_cnt++;
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result with nothing expected: proj %0d grad %0d",
                                  m_projected, m_gradient);
                end else begin
                    want = expected_q.pop_front();
                    if (m_projected !== want.projected || m_gradient !== want.gradient) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: proj exp %0d got %0d, grad exp %0d got %0d",
                                     want.projected, m_projected, want.gradient, m_gradient);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tanh_threshold_projection_core_tb.sv =====
// stimulus and verdict for the tanh threshold projection core
// depends on ttp_pkg, tanh_threshold_projection_core, tanh_threshold_projection_checker
module tanh_threshold_projection_core_tb;
    import ttp_pkg::*;

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           cfg_wr_en = 0;
    logic [0:0]     cfg_index = 0;
    logic [D_W-1:0] cfg_wdata = 0;
    logic           s_valid = 0;
    logic           s_ready;
    logic [D_W-1:0] s_density = 0;
    logic           m_valid;
    logic           m_ready = 0;
    logic [D_W-1:0] m_projected;
    logic [G_W-1:0] m_gradient;
    int             mismatch_cnt, pending_cnt, result_cnt;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             item_cnt = 0;
    logic [D_W-1:0] cur_thr = THRESHOLD_RST;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    tanh_threshold_projection_core DUT (.*);

    tanh_threshold_projection_checker checker_i (.*);

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_density(input logic [D_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_density <= d;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        item_cnt++;
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
        repeat (2 * FRAC_BITS_DEF + 90) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [D_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [D_W-1:0] pick_density();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 0;
            1: return ONE_Q16;
            2: return D_W'($urandom_range(131071, 65537));
            3: return (cur_thr > ONE_Q16) ? ONE_Q16
                    : D_W'(int'(cur_thr) + $urandom_range(64) - 32 < 0 ? 0
                    : int'(cur_thr) + $urandom_range(64) - 32);
            4: return D_W'($urandom_range(131071));
            default: return D_W'($urandom_range(65536));
        endcase
    endfunction

    initial begin
        logic [D_W-1:0] thr_set[8];
        logic [B_W-1:0] steep_set[8];
        logic [D_W-1:0] d0;
        thr_set = '{THRESHOLD_RST, 0, ONE_Q16, 131071, 20000, 50000, 1, 65535};
        steep_set = '{STEEPNESS_RST, 256, 65535, 1000, 2560, 16'hFFFF, 1, 128};
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // reset settings first: pass-through at the field extremes
        foreach (thr_set[p]) begin
            if (p >= 6) begin
                thr_set[p] = D_W'($urandom_range(131071));
                steep_set[p] = B_W'($urandom_range(65535));
            end
            if (p > 0) begin
                drain();
                write_reg(REG_THRESHOLD, thr_set[p]);
                write_reg(REG_STEEPNESS, D_W'(steep_set[p]));
                cur_thr = thr_set[p];
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (p < 2 || p == 4) begin
                send_density(0);
                send_density(1);
                send_density(65535);
                send_density(ONE_Q16);
                send_density(65537);
                send_density(131071);
                send_density(cur_thr);
                send_density(cur_thr - 1);
                send_density(cur_thr + 1);
            end
            for (int i = 0; i < 200; i++) begin
                // hold off once mid-phase until the pipe is empty
                if (p == 3 && i == 100) begin
                    s_valid <= 0;
                    @(posedge aclk);
                    while (pending_cnt != 0) @(posedge aclk);
                end
                d0 = pick_density();
                send_density(d0);
            end
        end
        drain();
        $display("covered %0d items, %0d results over %0d register settings",
                 item_cnt, result_cnt, 8);
        $display("idle modes: none, sender 83%%, receiver 83%%, both 26%%");
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ttp_pkg.sv
hdl/ttp_div.sv
hdl/ttp_term_cell.sv
hdl/ttp_tanh.sv
hdl/tanh_threshold_projection_core.sv
hdl/ttp_checker.sv
dv/tanh_threshold_projection_checker.sv
dv/tanh_threshold_projection_core_tb.sv
